>>> design/fta_pkg.sv
`default_nettype none
package fta_pkg;
	typedef enum logic [1:0] {
		STAT_RECORD  = 2'd0,
		STAT_EMPTY   = 2'd1,
		STAT_DROPPED = 2'd2
	} status_t;

	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	localparam int KEY_W   = 96;
	localparam int TIME_W  = 64;
	localparam int PKTS_W  = 32;
	localparam int BYTES_W = 48;

	// controller -> datapath commands
	typedef struct packed {
		logic load;      // capture input word, launch CAM match
		logic update;    // write hit entry
		logic alloc;     // write free entry
		logic rd_flow;   // read entry at scan slot
		logic emit_drop;
		logic emit_empty;
		logic emit_rec;
		logic rec_last;
		logic clr_slot;  // invalidate scan slot
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic op;
		logic hit;
		logic has_free;
		logic any_valid;
	} sts_t;
endpackage
`default_nettype wire

>>> design/flow_table_aggregator.sv
`default_nettype none
// Flow cache of TABLE_ENTRIES slots keyed by {src_addr, dst_addr, src_port, dst_port}.
// A word is taken when start is high and busy low. A packet word (op=0) goes through
// the parallel key match, then the read-modify-write of the counters; hits and
// new allocations give no result, a miss on a full table gives one status=2 result.
// A flush word (op=1) gives one record per valid slot in slot order (locate next slot,
// memory read, emit for each), last set on the final one, and leaves the table
// empty; an empty table gives one status=1 result. The receiver cannot
// stall: each result is on the ports for the single cycle that strobe is high.
module flow_table_aggregator #(
	parameter int TABLE_ENTRIES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        op,
	input  wire logic [31:0] src_addr,
	input  wire logic [31:0] dst_addr,
	input  wire logic [15:0] src_port,
	input  wire logic [15:0] dst_port,
	input  wire logic [31:0] ts_high,
	input  wire logic [31:0] ts_low,
	input  wire logic [15:0] pkt_length,
	output logic             strobe,
	output logic [31:0]      flow_src_addr,
	output logic [31:0]      flow_dst_addr,
	output logic [15:0]      flow_src_port,
	output logic [15:0]      flow_dst_port,
	output logic [31:0]      start_high,
	output logic [31:0]      start_low,
	output logic [31:0]      end_high,
	output logic [31:0]      end_low,
	output logic [31:0]      packet_total,
	output logic [47:0]      byte_total,
	output logic             last,
	output logic [1:0]       status
);
	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	fta_pkg::cmd_t cmd;
	fta_pkg::sts_t sts;
	logic [IDX_W-1:0] scan_idx;
	logic [TABLE_ENTRIES-1:0] valid_vec;

	fta_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES), .IDX_W(IDX_W)) u_ctrl (
		.clk, .arst_n, .start, .busy, .sts, .valid_vec, .cmd, .scan_idx
	);

	fta_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .IDX_W(IDX_W)) u_dp (
		.clk, .arst_n, .cmd, .scan_idx, .sts, .valid_vec,
		.op, .src_addr, .dst_addr, .src_port, .dst_port, .ts_high, .ts_low, .pkt_length,
		.strobe, .flow_src_addr, .flow_dst_addr, .flow_src_port, .flow_dst_port,
		.start_high, .start_low, .end_high, .end_low, .packet_total, .byte_total,
		.last, .status
	);
endmodule
`default_nettype wire

>>> design/fta_datapath.sv
`default_nettype none
module fta_datapath #(
	parameter int TABLE_ENTRIES = 64,
	parameter int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire fta_pkg::cmd_t          cmd,
	input  wire logic [IDX_W-1:0]       scan_idx,
	output fta_pkg::sts_t               sts,
	output logic [TABLE_ENTRIES-1:0]    valid_vec,
	input  wire logic                   op,
	input  wire logic [31:0]            src_addr,
	input  wire logic [31:0]            dst_addr,
	input  wire logic [15:0]            src_port,
	input  wire logic [15:0]            dst_port,
	input  wire logic [31:0]            ts_high,
	input  wire logic [31:0]            ts_low,
	input  wire logic [15:0]            pkt_length,
	output logic                        strobe,
	output logic [31:0]                 flow_src_addr,
	output logic [31:0]                 flow_dst_addr,
	output logic [15:0]                 flow_src_port,
	output logic [15:0]                 flow_dst_port,
	output logic [31:0]                 start_high,
	output logic [31:0]                 start_low,
	output logic [31:0]                 end_high,
	output logic [31:0]                 end_low,
	output logic [31:0]                 packet_total,
	output logic [47:0]                 byte_total,
	output logic                        last,
	output logic [1:0]                  status
);
	localparam int KW = fta_pkg::KEY_W;
	localparam int TW = fta_pkg::TIME_W;
	localparam int PW = fta_pkg::PKTS_W;
	localparam int BW = fta_pkg::BYTES_W;

	// keys are flops (parallel match); counters and times live in memories
	logic [KW-1:0] key_q [TABLE_ENTRIES];
	logic [TW-1:0] start_mem [TABLE_ENTRIES];
	logic [TW-1:0] end_mem [TABLE_ENTRIES];
	logic [PW-1:0] pkts_mem [TABLE_ENTRIES];
	logic [BW-1:0] bytes_mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic          op_q;
	logic [KW-1:0] in_key_q;
	logic [TW-1:0] in_ts_q;
	logic [15:0]   in_len_q;
	logic          hit_q, free_q;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q;
	logic [PW-1:0] rd_pkts_q;
	logic [BW-1:0] rd_bytes_q;
	logic [TW-1:0] rd_start_q, rd_end_q;

	logic [KW-1:0] cur_key;
	logic [TABLE_ENTRIES-1:0] match;
	logic          hit_c, free_c;
	logic [IDX_W-1:0] hit_idx_c, free_idx_c;

	assign cur_key = {src_addr, dst_addr, src_port, dst_port};

	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == cur_key);
		end
		hit_c = 1'b0;
		free_c = 1'b0;
		hit_idx_c = '0;
		free_idx_c = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_c = 1'b1;
				hit_idx_c = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_c = 1'b1;
				free_idx_c = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= op;
			in_key_q   <= cur_key;
			in_ts_q    <= {ts_high, ts_low};
			in_len_q   <= pkt_length;
			hit_q      <= hit_c;
			free_q     <= free_c;
			hit_idx_q  <= hit_idx_c;
			free_idx_q <= free_idx_c;
		end
	end

	// memory read port: hit slot during update, scan slot during flush
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_pkts_q  <= pkts_mem[hit_idx_c];
			rd_bytes_q <= bytes_mem[hit_idx_c];
		end else if (cmd.rd_flow) begin
			rd_pkts_q  <= pkts_mem[scan_idx];
			rd_bytes_q <= bytes_mem[scan_idx];
			rd_start_q <= start_mem[scan_idx];
			rd_end_q   <= end_mem[scan_idx];
		end
	end

	logic [PW-1:0] pkts_nx;
	logic [BW:0]   bsum;
	logic [BW-1:0] bytes_nx;
	assign pkts_nx  = (rd_pkts_q == '1) ? rd_pkts_q : rd_pkts_q + PW'(1);
	assign bsum     = {1'b0, rd_bytes_q} + (BW+1)'(in_len_q);
	assign bytes_nx = bsum[BW] ? '1 : bsum[BW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			end_mem[hit_idx_q]   <= in_ts_q;
			pkts_mem[hit_idx_q]  <= pkts_nx;
			bytes_mem[hit_idx_q] <= bytes_nx;
		end else if (cmd.alloc) begin
			start_mem[free_idx_q] <= in_ts_q;
			end_mem[free_idx_q]   <= in_ts_q;
			pkts_mem[free_idx_q]  <= PW'(1);
			bytes_mem[free_idx_q] <= BW'(in_len_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.alloc) begin
			key_q[free_idx_q] <= in_key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.alloc) begin
			valid_q[free_idx_q] <= 1'b1;
		end else if (cmd.clr_slot) begin
			valid_q[scan_idx] <= 1'b0;
		end
	end

	// result register
	logic [KW-1:0] okey_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= cmd.emit_drop | cmd.emit_empty | cmd.emit_rec;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_drop) begin
			okey_q       <= in_key_q;
			{start_high, start_low} <= '0;
			{end_high, end_low}     <= '0;
			packet_total <= '0;
			byte_total   <= '0;
			last         <= 1'b1;
			status       <= fta_pkg::STAT_DROPPED;
		end else if (cmd.emit_empty) begin
			okey_q       <= '0;
			{start_high, start_low} <= '0;
			{end_high, end_low}     <= '0;
			packet_total <= '0;
			byte_total   <= '0;
			last         <= 1'b1;
			status       <= fta_pkg::STAT_EMPTY;
		end else if (cmd.emit_rec) begin
			okey_q       <= key_q[scan_idx];
			{start_high, start_low} <= rd_start_q;
			{end_high, end_low}     <= rd_end_q;
			packet_total <= rd_pkts_q;
			byte_total   <= rd_bytes_q;
			last         <= cmd.rec_last;
			status       <= fta_pkg::STAT_RECORD;
		end
	end
	assign {flow_src_addr, flow_dst_addr, flow_src_port, flow_dst_port} = okey_q;

	assign valid_vec     = valid_q;
	assign sts.op        = op_q;
	assign sts.hit       = hit_q;
	assign sts.has_free  = free_q;
	assign sts.any_valid = |valid_q;

	property p_alloc_free;
		@(posedge clk) disable iff (!arst_n) cmd.alloc |-> !valid_q[free_idx_q];
	endproperty
	a_alloc_free: assert property (p_alloc_free) else $error("alloc into valid slot");

	property p_update_valid;
		@(posedge clk) disable iff (!arst_n) cmd.update |-> valid_q[hit_idx_q];
	endproperty
	a_update_valid: assert property (p_update_valid) else $error("update of invalid slot");

	property p_one_emit;
		@(posedge clk) disable iff (!arst_n)
			$onehot0({cmd.emit_drop, cmd.emit_empty, cmd.emit_rec});
	endproperty
	a_one_emit: assert property (p_one_emit) else $error("two results in one cycle");
endmodule
`default_nettype wire

>>> design/fta_ctrl.sv
`default_nettype none
module fta_ctrl #(
	parameter int TABLE_ENTRIES = 64,
	parameter int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire fta_pkg::sts_t          sts,
	input  wire logic [TABLE_ENTRIES-1:0] valid_vec,
	output fta_pkg::cmd_t               cmd,
	output logic [IDX_W-1:0]            scan_idx
);
	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DEC    = 5'b00010,
		S_FIND   = 5'b00100,
		S_READ   = 5'b01000,
		S_EMIT   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic [IDX_W-1:0] scan_q, scan_d;

	// next valid slot and whether one follows it
	logic             nxt_found;
	logic [IDX_W-1:0] nxt_idx;
	logic             more;
	always_comb begin
		nxt_found = 1'b0;
		nxt_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (valid_vec[i]) begin
				nxt_found = 1'b1;
				nxt_idx = IDX_W'(i);
			end
		end
		more = 1'b0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (valid_vec[i] && IDX_W'(i) != scan_q) begin
				more = 1'b1;
			end
		end
	end

	always_comb begin
		cmd = '0;
		state_d = state_q;
		scan_d = scan_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.op == fta_pkg::OP_PACKET) begin
					if (sts.hit) begin
						cmd.update = 1'b1;
					end else if (sts.has_free) begin
						cmd.alloc = 1'b1;
					end else begin
						cmd.emit_drop = 1'b1;
					end
					state_d = S_IDLE;
				end else if (!sts.any_valid) begin
					cmd.emit_empty = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_FIND;
				end
			end
			S_FIND: begin
				scan_d = nxt_idx;
				state_d = S_READ;
			end
			S_READ: begin
				cmd.rd_flow = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit_rec = 1'b1;
				cmd.rec_last = !more;
				cmd.clr_slot = 1'b1;
				state_d = more ? S_FIND : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scan_q <= '0;
		end else begin
			state_q <= state_d;
			scan_q <= scan_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign scan_idx = scan_q;

	property p_find_has_slot;
		@(posedge clk) disable iff (!arst_n) (state_q == S_FIND) |-> nxt_found;
	endproperty
	a_find_has_slot: assert property (p_find_has_slot) else $error("flush scan with no valid slot");

	property p_emit_after_read;
		@(posedge clk) disable iff (!arst_n) cmd.emit_rec |-> $past(cmd.rd_flow);
	endproperty
	a_emit_after_read: assert property (p_emit_after_read) else $error("record without read");

	property p_emit_valid;
		@(posedge clk) disable iff (!arst_n) cmd.emit_rec |-> valid_vec[scan_q];
	endproperty
	a_emit_valid: assert property (p_emit_valid) else $error("record of invalid slot");
endmodule
`default_nettype wire

>>> tb/sv/tb_flow_table_aggregator.sv
`default_nettype none
module tb_flow_table_aggregator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 64;
	localparam int RUN_ITEMS = 300;
	// drain time: enough for a full flush of every slot, plus margin
	localparam int DRAIN_CYCLES = 3 * SLOTS + 40;

	// one input word
	typedef struct {
		logic        op;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [31:0] ts_high;
		logic [31:0] ts_low;
		logic [15:0] pkt_length;
	} pkt_word_t;

	// one result word
	typedef struct {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [31:0] start_high;
		logic [31:0] start_low;
		logic [31:0] end_high;
		logic [31:0] end_low;
		logic [31:0] packets;
		logic [47:0] bytes;
		logic        last;
		fta_pkg::status_t status;
	} flow_rec_t;

	// directed row: typed flag says the expectation below is written by hand
	typedef struct {
		pkt_word_t w;
		bit        typed;
		flow_rec_t rec;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        op;
	logic [31:0] src_addr;
	logic [31:0] dst_addr;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	logic [31:0] ts_high;
	logic [31:0] ts_low;
	logic [15:0] pkt_length;
	logic        strobe;
	logic [31:0] flow_src_addr;
	logic [31:0] flow_dst_addr;
	logic [15:0] flow_src_port;
	logic [15:0] flow_dst_port;
	logic [31:0] start_high;
	logic [31:0] start_low;
	logic [31:0] end_high;
	logic [31:0] end_low;
	logic [31:0] packet_total;
	logic [47:0] byte_total;
	logic        last;
	logic [1:0]  status;

	flow_table_aggregator #(.TABLE_ENTRIES(SLOTS)) dut (.*);

	// shadow flow cache
	bit          cache_valid [SLOTS];
	logic [63:0] cache_key [SLOTS];
	logic [31:0] cache_ports [SLOTS];
	logic [63:0] cache_first [SLOTS];
	logic [63:0] cache_latest [SLOTS];
	logic [31:0] cache_pkts [SLOTS];
	logic [47:0] cache_bytes [SLOTS];

	flow_rec_t pending_recs[$];
	int        fail_count = 0;
	int        idle_pct = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("[flow_table_aggregator] ERROR");
		$finish;
	end

	// Update the shadow cache with one word; results go to out_q.
	task automatic cache_apply(input pkt_word_t w, inout flow_rec_t out_q[$]);
		logic [63:0] key;
		logic [31:0] ports;
		logic [48:0] sum;
		flow_rec_t   r;
		int          hit;
		int          free_slot;
		int          top;
		key = {w.src_addr, w.dst_addr};
		ports = {w.src_port, w.dst_port};
		hit = -1;
		free_slot = -1;
		top = -1;
		r = '{default: '0, status: fta_pkg::STAT_RECORD};
		if (w.op == fta_pkg::OP_PACKET) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (cache_valid[i]) begin
					if (hit < 0 && cache_key[i] == key && cache_ports[i] == ports)
						hit = i;
				end else if (free_slot < 0) begin
					free_slot = i;
				end
			end
			if (hit >= 0) begin
				cache_latest[hit] = {w.ts_high, w.ts_low};
				if (cache_pkts[hit] != '1)
					cache_pkts[hit] = cache_pkts[hit] + 32'd1;
				sum = 49'(cache_bytes[hit]) + 49'(w.pkt_length);
				cache_bytes[hit] = sum[48] ? '1 : sum[47:0];
			end else if (free_slot >= 0) begin
				cache_valid[free_slot] = 1'b1;
				cache_key[free_slot] = key;
				cache_ports[free_slot] = ports;
				cache_first[free_slot] = {w.ts_high, w.ts_low};
				cache_latest[free_slot] = {w.ts_high, w.ts_low};
				cache_pkts[free_slot] = 32'd1;
				cache_bytes[free_slot] = 48'(w.pkt_length);
			end else begin
				// table full: drop report carries the key only
				r.src_addr = w.src_addr;
				r.dst_addr = w.dst_addr;
				r.src_port = w.src_port;
				r.dst_port = w.dst_port;
				r.last = 1'b1;
				r.status = fta_pkg::STAT_DROPPED;
				out_q.insert(out_q.size(), r);
			end
		end else begin
			for (int i = 0; i < SLOTS; i++)
				if (cache_valid[i])
					top = i;
			if (top < 0) begin
				r.last = 1'b1;
				r.status = fta_pkg::STAT_EMPTY;
				out_q.insert(out_q.size(), r);
			end
			for (int i = 0; i < SLOTS; i++) begin
				if (cache_valid[i]) begin
					r.src_addr = cache_key[i][63:32];
					r.dst_addr = cache_key[i][31:0];
					r.src_port = cache_ports[i][31:16];
					r.dst_port = cache_ports[i][15:0];
					r.start_high = cache_first[i][63:32];
					r.start_low = cache_first[i][31:0];
					r.end_high = cache_latest[i][63:32];
					r.end_low = cache_latest[i][31:0];
					r.packets = cache_pkts[i];
					r.bytes = cache_bytes[i];
					r.last = (i == top);
					r.status = fta_pkg::STAT_RECORD;
					out_q.insert(out_q.size(), r);
					cache_valid[i] = 1'b0;
				end
			end
		end
	endtask

	// Present one word, sometimes after a random gap, and hold it until taken.
	task automatic send_word(input pkt_word_t w, input bit typed, input flow_rec_t rec);
		flow_rec_t discard[$];
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		op <= w.op;
		src_addr <= w.src_addr;
		dst_addr <= w.dst_addr;
		src_port <= w.src_port;
		dst_port <= w.dst_port;
		ts_high <= w.ts_high;
		ts_low <= w.ts_low;
		pkt_length <= w.pkt_length;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (typed) begin
			cache_apply(w, discard);
			pending_recs.insert(pending_recs.size(), rec);
		end else begin
			cache_apply(w, pending_recs);
		end
	endtask

	task automatic send_pred(input pkt_word_t w);
		send_word(w, 1'b0, '{default: '0, status: fta_pkg::STAT_RECORD});
	endtask

	function automatic pkt_word_t rand_packet(input logic [95:0] flow_key);
		pkt_word_t w;
		w.op = fta_pkg::OP_PACKET;
		{w.src_addr, w.dst_addr, w.src_port, w.dst_port} = flow_key;
		w.ts_high = $urandom;
		w.ts_low = $urandom;
		w.pkt_length = 16'($urandom);
		return w;
	endfunction

	task automatic check_field(input string name, input logic [47:0] exp_v,
			input logic [47:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// results cannot be stalled: check every strobe cycle
	always @(posedge clk) begin
		flow_rec_t e;
		if (arst_n && strobe) begin
			if (pending_recs.size() == 0) begin
				$error("unexpected result word, status %0d", status);
				fail_count++;
			end else begin
				e = pending_recs.pop_front();
				check_field("flow_src_addr", 48'(e.src_addr), 48'(flow_src_addr));
				check_field("flow_dst_addr", 48'(e.dst_addr), 48'(flow_dst_addr));
				check_field("flow_src_port", 48'(e.src_port), 48'(flow_src_port));
				check_field("flow_dst_port", 48'(e.dst_port), 48'(flow_dst_port));
				check_field("start_high", 48'(e.start_high), 48'(start_high));
				check_field("start_low", 48'(e.start_low), 48'(start_low));
				check_field("end_high", 48'(e.end_high), 48'(end_high));
				check_field("end_low", 48'(e.end_low), 48'(end_low));
				check_field("packet_total", 48'(e.packets), 48'(packet_total));
				check_field("byte_total", e.bytes, byte_total);
				check_field("last", 48'(e.last), 48'(last));
				check_field("status", 48'(e.status), 48'(status));
			end
		end
	end

	initial begin
		dir_row_t    dir_rows[$];
		dir_row_t    row;
		pkt_word_t   w;
		flow_rec_t   none_rec;
		logic [95:0] key_pool[$];
		int          sent;
		int          n_keys;
		int          n_pkts;
		int          idle_plan[3];
		int          wait_cycles;
		bit          held;

		arst_n = 1'b0;
		start = 1'b0;
		op = fta_pkg::OP_PACKET;
		src_addr = '0;
		dst_addr = '0;
		src_port = '0;
		dst_port = '0;
		ts_high = '0;
		ts_low = '0;
		pkt_length = '0;
		none_rec = '{default: '0, status: fta_pkg::STAT_RECORD};
		for (int i = 0; i < SLOTS; i++)
			cache_valid[i] = 1'b0;

		// directed rows
		row = '{w: '{default: '0, op: fta_pkg::OP_FLUSH}, typed: 1'b1, rec: none_rec};
		row.rec.last = 1'b1;
		row.rec.status = fta_pkg::STAT_EMPTY;  // flush right after reset
		dir_rows.insert(dir_rows.size(), row);
		row = '{w: '{op: fta_pkg::OP_PACKET, src_addr: '1, dst_addr: '1, src_port: '1,
			dst_port: '1, ts_high: '1, ts_low: '1, pkt_length: '1},
			typed: 1'b0, rec: none_rec};
		dir_rows.insert(dir_rows.size(), row);  // all-ones key, max length
		dir_rows.insert(dir_rows.size(), row);  // hit on it
		row.w = '{op: fta_pkg::OP_PACKET, default: '0};
		dir_rows.insert(dir_rows.size(), row);  // all-zero key and length
		row.w = '{op: fta_pkg::OP_PACKET, src_addr: 32'h8000_0001, dst_addr: 32'h0000_0001,
			src_port: 16'h8000, dst_port: 16'h0001, ts_high: 32'h1, ts_low: 32'h0,
			pkt_length: 16'h0040};
		dir_rows.insert(dir_rows.size(), row);
		row.w.dst_port = 16'h0002;             // differs only in dst_port: new flow
		dir_rows.insert(dir_rows.size(), row);
		row.w.ts_high = 32'h2;
		row.w.pkt_length = 16'hFFFF;
		dir_rows.insert(dir_rows.size(), row);  // hit, end time moves
		row.w = '{op: fta_pkg::OP_FLUSH, default: '0};
		dir_rows.insert(dir_rows.size(), row);  // four records
		row.typed = 1'b1;
		row.rec = none_rec;
		row.rec.last = 1'b1;
		row.rec.status = fta_pkg::STAT_EMPTY;
		dir_rows.insert(dir_rows.size(), row);  // table now empty again

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].rec);

		// random episodes: packets over a key pool, then a flush.
		// Pools above the table size give dropped packets.
		idle_plan = '{10, 68, 0};
		sent = 0;
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = idle_plan[ph];
			held = 1'b0;
			while (sent < (ph + 1) * RUN_ITEMS / 3) begin
				n_keys = ($urandom_range(3) == 0) ? $urandom_range(SLOTS, SLOTS + 6)
					: $urandom_range(1, 12);
				n_pkts = (n_keys >= SLOTS) ? n_keys + $urandom_range(2, 8)
					: $urandom_range(1, 30);
				key_pool.delete();
				for (int k = 0; k < n_keys; k++)
					key_pool.insert(key_pool.size(), {$urandom, $urandom, $urandom});
				for (int p = 0; p < n_pkts; p++) begin
					// walk the pool once so large pools fill the table
					if (p < n_keys)
						w = rand_packet(key_pool[p]);
					else
						w = rand_packet(key_pool[$urandom_range(n_keys - 1)]);
					// occasional stray flush mid-episode
					if ($urandom_range(29) == 0)
						w.op = fta_pkg::OP_FLUSH;
					send_pred(w);
					sent++;
				end
				w = '{op: fta_pkg::OP_FLUSH, default: '0};
				send_pred(w);
				sent++;
				// hold off at least once per phase until everything has come out
				if ($urandom_range(3) == 0 || !held) begin
					held = 1'b1;
					start <= 1'b0;
					@(posedge clk);
					while (pending_recs.size() != 0)
						@(posedge clk);
				end
			end
		end

		start <= 1'b0;
		wait_cycles = 0;
		while (pending_recs.size() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_recs.size() == 0) begin
			$display("[flow_table_aggregator] OK");
		end else begin
			$display("[flow_table_aggregator] ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> filelist.f
design/fta_pkg.sv
design/fta_datapath.sv
design/fta_ctrl.sv
design/flow_table_aggregator.sv
tb/sv/tb_flow_table_aggregator.sv
